// ===== rtl/mlp_pkg.sv =====
// mlp_pkg: sizes, memory layout, item and command types and arithmetic helpers
// for the three-layer regressor. No dependencies.
`default_nettype none

package mlp_pkg;

  localparam int INPUT_COUNT     = 3;
  localparam int HIDDEN_ONE_SIZE = 32;
  localparam int HIDDEN_TWO_SIZE = 16;
  localparam int PARAM_DEPTH     = 1024;
  localparam int RESULT_COUNT    = 2;

  localparam int PA_W   = $clog2(PARAM_DEPTH);
  localparam int MAX_N  = (HIDDEN_ONE_SIZE > HIDDEN_TWO_SIZE) ? HIDDEN_ONE_SIZE : HIDDEN_TWO_SIZE;
  localparam int IDX_W  = ($clog2(MAX_N) < 2) ? 2 : $clog2(MAX_N);
  localparam int H1_W   = (HIDDEN_ONE_SIZE > 1) ? $clog2(HIDDEN_ONE_SIZE) : 1;
  localparam int H2_W   = (HIDDEN_TWO_SIZE > 1) ? $clog2(HIDDEN_TWO_SIZE) : 1;
  localparam int ACC_W  = 56;
  localparam int PROD_W = 65;
  localparam int SH_W   = 49;

  localparam int OFS_WA     = 0;
  localparam int OFS_BA     = OFS_WA + HIDDEN_ONE_SIZE * INPUT_COUNT;
  localparam int OFS_WB     = OFS_BA + HIDDEN_ONE_SIZE;
  localparam int OFS_BB     = OFS_WB + HIDDEN_TWO_SIZE * HIDDEN_ONE_SIZE;
  localparam int OFS_WC     = OFS_BB + HIDDEN_TWO_SIZE;
  localparam int OFS_BC     = OFS_WC + RESULT_COUNT * HIDDEN_TWO_SIZE;
  localparam int OFS_IMEAN  = OFS_BC + RESULT_COUNT;
  localparam int OFS_IRECIP = OFS_IMEAN + INPUT_COUNT;
  localparam int OFS_OSCALE = OFS_IRECIP + INPUT_COUNT;
  localparam int OFS_OMEAN  = OFS_OSCALE + RESULT_COUNT;

  localparam logic [1:0] LAY_ONE = 2'd0;
  localparam logic [1:0] LAY_TWO = 2'd1;
  localparam logic [1:0] LAY_OUT = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_INFER = 1'b1;

  typedef struct packed {
    logic               func;
    logic [9:0]         param_addr;
    logic signed [31:0] param_word;
    logic signed [31:0] reading_254;
    logic signed [31:0] reading_550;
    logic signed [31:0] reading_temp;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] cod_estimate;
    logic signed [31:0] uv254_estimate;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN,
    ST_RECIP,
    ST_BIAS,
    ST_MAC,
    ST_STORE,
    ST_OSCALE,
    ST_OMEAN,
    ST_DRAIN
  } state_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MEAN,
    OP_RECIP,
    OP_BIAS,
    OP_MAC,
    OP_STORE,
    OP_OSCALE,
    OP_OMEAN
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [1:0]       layer;
    logic [IDX_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    tag_t            tag;
    logic [PA_W-1:0] addr;
    logic            load_we;
    logic            latch;
  } cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (!v[ACC_W-1] && (|v[ACC_W-2:31])) begin
      r = 32'sh7FFF_FFFF;
    end else if (v[ACC_W-1] && !(&v[ACC_W-2:31])) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [PA_W-1:0] wofs(input logic [1:0] lay);
    logic [PA_W-1:0] r;
    unique case (lay)
      LAY_ONE: r = PA_W'(OFS_WA);
      LAY_TWO: r = PA_W'(OFS_WB);
      default: r = PA_W'(OFS_WC);
    endcase
    return r;
  endfunction

  function automatic logic [PA_W-1:0] bofs(input logic [1:0] lay);
    logic [PA_W-1:0] r;
    unique case (lay)
      LAY_ONE: r = PA_W'(OFS_BA);
      LAY_TWO: r = PA_W'(OFS_BB);
      default: r = PA_W'(OFS_BC);
    endcase
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] last_in(input logic [1:0] lay);
    logic [IDX_W-1:0] r;
    unique case (lay)
      LAY_ONE: r = IDX_W'(INPUT_COUNT - 1);
      LAY_TWO: r = IDX_W'(HIDDEN_ONE_SIZE - 1);
      default: r = IDX_W'(HIDDEN_TWO_SIZE - 1);
    endcase
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] last_out(input logic [1:0] lay);
    logic [IDX_W-1:0] r;
    unique case (lay)
      LAY_ONE: r = IDX_W'(HIDDEN_ONE_SIZE - 1);
      LAY_TWO: r = IDX_W'(HIDDEN_TWO_SIZE - 1);
      default: r = IDX_W'(RESULT_COUNT - 1);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mlp_three_layer_regressor.sv =====
// mlp_three_layer_regressor: top level, sequencer plus MAC datapath.
// Load item: written on the accepting edge, busy stays low, no result.
// Sample item: out_valid strobes once both estimates are registered; busy drops in that same cycle.
// Rate set by the single shared multiply-accumulate unit and memory read port.
// Synchronous active-low reset clears control only; parameter memory is undefined.
`default_nettype none

module mlp_three_layer_regressor (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire mlp_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output mlp_pkg::out_item_t      out_item
);

  mlp_pkg::cmd_t cmd;

  mlp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_item.func),
    .busy  (busy),
    .cmd   (cmd)
  );

  mlp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== rtl/mlp_ctrl.sv =====
// mlp_ctrl: sequencer issuing one parameter read and datapath command per cycle.
// Depends on mlp_pkg.
`default_nettype none

module mlp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          func,
  output logic               busy,
  output mlp_pkg::cmd_t      cmd
);

  mlp_pkg::state_t                state_r, state_nxt;
  logic [1:0]                     k_r, k_nxt;
  logic [1:0]                     layer_r, layer_nxt;
  logic [mlp_pkg::IDX_W-1:0]      row_r, row_nxt;
  logic [mlp_pkg::IDX_W-1:0]      col_r, col_nxt;
  logic [mlp_pkg::PA_W-1:0]       waddr_r, waddr_nxt;
  logic [1:0]                     drain_r, drain_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlp_pkg::ST_IDLE;
      k_r     <= '0;
      layer_r <= mlp_pkg::LAY_ONE;
      row_r   <= '0;
      col_r   <= '0;
      waddr_r <= '0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      layer_r <= layer_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      waddr_r <= waddr_nxt;
      drain_r <= drain_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    layer_nxt = layer_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    waddr_nxt = waddr_r;
    drain_nxt = drain_r;
    unique case (state_r)
      mlp_pkg::ST_IDLE: begin
        if (start && func == mlp_pkg::FUNC_INFER) begin
          state_nxt = mlp_pkg::ST_MEAN;
          k_nxt     = '0;
        end
      end
      mlp_pkg::ST_MEAN: begin
        state_nxt = mlp_pkg::ST_RECIP;
      end
      mlp_pkg::ST_RECIP: begin
        if (k_r == 2'(mlp_pkg::INPUT_COUNT - 1)) begin
          state_nxt = mlp_pkg::ST_BIAS;
          layer_nxt = mlp_pkg::LAY_ONE;
          row_nxt   = '0;
          waddr_nxt = mlp_pkg::wofs(mlp_pkg::LAY_ONE);
        end else begin
          state_nxt = mlp_pkg::ST_MEAN;
          k_nxt     = k_r + 2'd1;
        end
      end
      mlp_pkg::ST_BIAS: begin
        state_nxt = mlp_pkg::ST_MAC;
        col_nxt   = '0;
      end
      mlp_pkg::ST_MAC: begin
        waddr_nxt = waddr_r + 1'b1;
        if (col_r == mlp_pkg::last_in(layer_r)) begin
          state_nxt = mlp_pkg::ST_STORE;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      mlp_pkg::ST_STORE: begin
        if (row_r == mlp_pkg::last_out(layer_r)) begin
          if (layer_r == mlp_pkg::LAY_OUT) begin
            state_nxt = mlp_pkg::ST_OSCALE;
            k_nxt     = '0;
          end else begin
            state_nxt = mlp_pkg::ST_BIAS;
            layer_nxt = layer_r + 2'd1;
            row_nxt   = '0;
            waddr_nxt = mlp_pkg::wofs(layer_r + 2'd1);
          end
        end else begin
          state_nxt = mlp_pkg::ST_BIAS;
          row_nxt   = row_r + 1'b1;
        end
      end
      mlp_pkg::ST_OSCALE: begin
        state_nxt = mlp_pkg::ST_OMEAN;
      end
      mlp_pkg::ST_OMEAN: begin
        if (k_r == 2'(mlp_pkg::RESULT_COUNT - 1)) begin
          state_nxt = mlp_pkg::ST_DRAIN;
          drain_nxt = '0;
        end else begin
          state_nxt = mlp_pkg::ST_OSCALE;
          k_nxt     = k_r + 2'd1;
        end
      end
      mlp_pkg::ST_DRAIN: begin
        drain_nxt = drain_r + 2'd1;
        if (drain_r == 2'd1) begin
          state_nxt = mlp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mlp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.tag.op    = mlp_pkg::OP_NOP;
    cmd.tag.layer = layer_r;
    busy          = 1'b1;
    unique case (state_r)
      mlp_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.load_we = start && (func == mlp_pkg::FUNC_LOAD);
        cmd.latch   = start && (func == mlp_pkg::FUNC_INFER);
      end
      mlp_pkg::ST_MEAN: begin
        cmd.tag.op  = mlp_pkg::OP_MEAN;
        cmd.tag.idx = mlp_pkg::IDX_W'(k_r);
        cmd.addr    = mlp_pkg::PA_W'(mlp_pkg::OFS_IMEAN) + mlp_pkg::PA_W'(k_r);
      end
      mlp_pkg::ST_RECIP: begin
        cmd.tag.op  = mlp_pkg::OP_RECIP;
        cmd.tag.idx = mlp_pkg::IDX_W'(k_r);
        cmd.addr    = mlp_pkg::PA_W'(mlp_pkg::OFS_IRECIP) + mlp_pkg::PA_W'(k_r);
      end
      mlp_pkg::ST_BIAS: begin
        cmd.tag.op  = mlp_pkg::OP_BIAS;
        cmd.tag.idx = row_r;
        cmd.addr    = mlp_pkg::bofs(layer_r) + mlp_pkg::PA_W'(row_r);
      end
      mlp_pkg::ST_MAC: begin
        cmd.tag.op  = mlp_pkg::OP_MAC;
        cmd.tag.idx = col_r;
        cmd.addr    = waddr_r;
      end
      mlp_pkg::ST_STORE: begin
        cmd.tag.op  = mlp_pkg::OP_STORE;
        cmd.tag.idx = row_r;
      end
      mlp_pkg::ST_OSCALE: begin
        cmd.tag.op  = mlp_pkg::OP_OSCALE;
        cmd.tag.idx = mlp_pkg::IDX_W'(k_r);
        cmd.addr    = mlp_pkg::PA_W'(mlp_pkg::OFS_OSCALE) + mlp_pkg::PA_W'(k_r);
      end
      mlp_pkg::ST_OMEAN: begin
        cmd.tag.op  = mlp_pkg::OP_OMEAN;
        cmd.tag.idx = mlp_pkg::IDX_W'(k_r);
        cmd.addr    = mlp_pkg::PA_W'(mlp_pkg::OFS_OMEAN) + mlp_pkg::PA_W'(k_r);
      end
      mlp_pkg::ST_DRAIN: begin
        cmd.tag.op = mlp_pkg::OP_NOP;
      end
      default: begin
        cmd.tag.op = mlp_pkg::OP_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mlp_dp.sv =====
// mlp_dp: parameter memory, shared multiplier and accumulator, hidden stores
// and result registers. Depends on mlp_pkg.
`default_nettype none

module mlp_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mlp_pkg::cmd_t      cmd,
  input  wire mlp_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output mlp_pkg::out_item_t      out_item
);

  logic signed [31:0] param_mem [mlp_pkg::PARAM_DEPTH];
  logic signed [31:0] rdata_r, rdata2_r;

  logic signed [31:0] rd_r   [mlp_pkg::INPUT_COUNT];
  logic signed [31:0] std_r  [mlp_pkg::INPUT_COUNT];
  logic signed [31:0] h1_r   [mlp_pkg::HIDDEN_ONE_SIZE];
  logic signed [31:0] h2_r   [mlp_pkg::HIDDEN_TWO_SIZE];
  logic signed [31:0] raw_r  [mlp_pkg::RESULT_COUNT];

  mlp_pkg::tag_t                    p1_r, p2_r;
  logic signed [32:0]               d_r;
  logic signed [mlp_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [mlp_pkg::ACC_W-1:0]  acc_r;
  logic signed [31:0]               x;
  logic signed [32:0]               mul_a;
  logic signed [mlp_pkg::PROD_W-1:0] prod_sh;
  logic signed [mlp_pkg::SH_W-1:0]   sh;
  logic signed [mlp_pkg::ACC_W-1:0]  sh_ext;
  logic signed [31:0]               acc_sat, store_val, y_sat;
  logic signed [mlp_pkg::ACC_W-1:0]  y;
  logic [mlp_pkg::PA_W:0]           load_addr;
  logic                             out_valid_r;
  logic signed [31:0]               cod_r, uv_r;

  // parameter memory: one write (load item) and one read per cycle
  assign load_addr = (mlp_pkg::PA_W + 1)'(in_item.param_addr);

  always_ff @(posedge clk) begin
    if (cmd.load_we && load_addr < (mlp_pkg::PA_W + 1)'(mlp_pkg::PARAM_DEPTH)) begin
      param_mem[load_addr[mlp_pkg::PA_W-1:0]] <= in_item.param_word;
    end
    rdata_r  <= param_mem[cmd.addr];
    rdata2_r <= rdata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r        <= '0;
      p2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      p1_r        <= cmd.tag;
      p2_r        <= p1_r;
      out_valid_r <= (p2_r.op == mlp_pkg::OP_OMEAN) &&
                     (p2_r.idx == mlp_pkg::IDX_W'(mlp_pkg::RESULT_COUNT - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      rd_r[0] <= in_item.reading_254;
      rd_r[1] <= in_item.reading_550;
      rd_r[2] <= in_item.reading_temp;
    end
  end

  // stage 1: operand select, mean subtraction and multiply
  always_comb begin
    unique case (p1_r.layer)
      mlp_pkg::LAY_ONE: x = std_r[p1_r.idx[1:0]];
      mlp_pkg::LAY_TWO: x = h1_r[p1_r.idx[mlp_pkg::H1_W-1:0]];
      default:          x = h2_r[p1_r.idx[mlp_pkg::H2_W-1:0]];
    endcase
    unique case (p1_r.op)
      mlp_pkg::OP_RECIP:  mul_a = d_r;
      mlp_pkg::OP_OSCALE: mul_a = 33'(raw_r[p1_r.idx[0]]);
      default:            mul_a = 33'(x);
    endcase
    prod_nxt = mul_a * rdata_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (p1_r.op == mlp_pkg::OP_MEAN) begin
      d_r <= 33'(rd_r[p1_r.idx[1:0]]) - 33'(rdata_r);
    end
  end

  // stage 2: accumulate, saturate, store
  always_comb begin
    prod_sh   = prod_r >>> 16;
    sh        = prod_sh[mlp_pkg::SH_W-1:0];
    sh_ext    = mlp_pkg::ACC_W'(sh);
    acc_sat   = mlp_pkg::sat32(acc_r);
    store_val = (p2_r.layer != mlp_pkg::LAY_OUT && acc_sat[31]) ? 32'sd0 : acc_sat;
    y         = acc_r + mlp_pkg::ACC_W'(rdata2_r);
    y_sat     = mlp_pkg::sat32(y);
  end

  always_ff @(posedge clk) begin
    unique case (p2_r.op)
      mlp_pkg::OP_RECIP: begin
        std_r[p2_r.idx[1:0]] <= mlp_pkg::sat32(sh_ext);
      end
      mlp_pkg::OP_BIAS: begin
        acc_r <= mlp_pkg::ACC_W'(rdata2_r);
      end
      mlp_pkg::OP_MAC: begin
        acc_r <= acc_r + sh_ext;
      end
      mlp_pkg::OP_OSCALE: begin
        acc_r <= sh_ext;
      end
      mlp_pkg::OP_STORE: begin
        unique case (p2_r.layer)
          mlp_pkg::LAY_ONE: h1_r[p2_r.idx[mlp_pkg::H1_W-1:0]] <= store_val;
          mlp_pkg::LAY_TWO: h2_r[p2_r.idx[mlp_pkg::H2_W-1:0]] <= store_val;
          default:          raw_r[p2_r.idx[0]] <= store_val;
        endcase
      end
      mlp_pkg::OP_OMEAN: begin
        if (p2_r.idx[0]) begin
          uv_r <= y_sat;
        end else begin
          cod_r <= y_sat;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid               = out_valid_r;
  assign out_item.cod_estimate   = cod_r;
  assign out_item.uv254_estimate = uv_r;

endmodule

`default_nettype wire

// ===== test/mlp_estimate_checker.sv =====
// mlp_estimate_checker: watches the sample and result channels of the regressor,
// keeps a shadow of the parameter memory, predicts each estimate and compares it.
// Depends on mlp_pkg for item types, sizes and the memory layout.
module mlp_estimate_checker
  import mlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        mismatch_count,
  output int        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [95:0] wide_t;

  logic signed [31:0] param_shadow [PARAM_DEPTH];
  out_item_t          estimate_q [$];
  out_item_t          expected;
  int                 mismatches = 0;
  int                 pending = 0;

  assign mismatch_count = mismatches;
  assign pending_count  = pending;

  function automatic logic signed [31:0] clamp32(input wide_t v);
    if (v > wide_t'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < wide_t'(32'sh8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Q16.16 product, floored
  function automatic wide_t fixed_mul(input wide_t a, input wide_t b);
    return (a * b) >>> 16;
  endfunction

  function automatic logic signed [31:0] relu(input logic signed [31:0] v);
    return v[31] ? 32'sd0 : v;
  endfunction

  function automatic logic signed [31:0] neuron_out(input logic signed [31:0] ins [MAX_N],
                                                    input int n_in, input int w_base,
                                                    input int b_addr);
    wide_t acc;
    acc = wide_t'(param_shadow[b_addr]);
    for (int c = 0; c < n_in; c++)
      acc += fixed_mul(wide_t'(ins[c]), wide_t'(param_shadow[w_base + c]));
    return clamp32(acc);
  endfunction

  function automatic out_item_t predict_estimate(input in_item_t it);
    logic signed [31:0] reading [INPUT_COUNT];
    logic signed [31:0] feat [MAX_N];
    logic signed [31:0] hid_a [MAX_N];
    logic signed [31:0] hid_b [MAX_N];
    logic signed [31:0] raw;
    wide_t              y [RESULT_COUNT];
    out_item_t          est;
    reading[0] = it.reading_254;
    reading[1] = it.reading_550;
    reading[2] = it.reading_temp;
    feat  = '{default: '0};
    hid_a = '{default: '0};
    hid_b = '{default: '0};
    for (int k = 0; k < INPUT_COUNT; k++)
      feat[k] = clamp32(fixed_mul(wide_t'(reading[k]) - wide_t'(param_shadow[OFS_IMEAN + k]),
                                  wide_t'(param_shadow[OFS_IRECIP + k])));
    for (int r = 0; r < HIDDEN_ONE_SIZE; r++)
      hid_a[r] = relu(neuron_out(feat, INPUT_COUNT, OFS_WA + r * INPUT_COUNT, OFS_BA + r));
    for (int r = 0; r < HIDDEN_TWO_SIZE; r++)
      hid_b[r] = relu(neuron_out(hid_a, HIDDEN_ONE_SIZE, OFS_WB + r * HIDDEN_ONE_SIZE,
                                 OFS_BB + r));
    for (int k = 0; k < RESULT_COUNT; k++) begin
      raw  = neuron_out(hid_b, HIDDEN_TWO_SIZE, OFS_WC + k * HIDDEN_TWO_SIZE, OFS_BC + k);
      y[k] = fixed_mul(wide_t'(raw), wide_t'(param_shadow[OFS_OSCALE + k]))
             + wide_t'(param_shadow[OFS_OMEAN + k]);
    end
    est.cod_estimate   = clamp32(y[0]);
    est.uv254_estimate = clamp32(y[1]);
    return est;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (estimate_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no sample pending (cod %h, uv254 %h)", $time,
                     out_item.cod_estimate, out_item.uv254_estimate);
        end else begin
          expected = estimate_q.pop_front();
          if (out_item.cod_estimate !== expected.cod_estimate)
            flag_mismatch("cod_estimate", expected.cod_estimate, out_item.cod_estimate);
          if (out_item.uv254_estimate !== expected.uv254_estimate)
            flag_mismatch("uv254_estimate", expected.uv254_estimate, out_item.uv254_estimate);
        end
      end
      if (start && !busy) begin
        if (in_item.func == FUNC_INFER)
          estimate_q.push_back(predict_estimate(in_item));
        else if (int'(in_item.param_addr) < PARAM_DEPTH)
          param_shadow[in_item.param_addr] = in_item.param_word;
      end
      pending = estimate_q.size();
    end
  end

endmodule

// ===== test/mlp_three_layer_regressor_tb.sv =====
// mlp_three_layer_regressor_tb: loads a full parameter set, then directed and random
// load and sample items under varying sender gaps; verdict from mlp_estimate_checker.
// Depends on mlp_pkg, mlp_three_layer_regressor and mlp_estimate_checker.
module mlp_three_layer_regressor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mlp_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 760;
  localparam int RANDOM_ITEMS   = 110;
  localparam int MODEL_WORDS    = OFS_OMEAN + RESULT_COUNT;
  localparam int Q_ONE          = 65536;
  localparam int Q_TWO          = 2 * Q_ONE;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  int        mismatch_count;
  int        pending_count;
  int        idle_pct;
  int        quiet_cycles = 0;

  logic signed [31:0] param_image [MODEL_WORDS];

  always #CLK_HALF clk = ~clk;

  mlp_three_layer_regressor u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  mlp_estimate_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("mlp_three_layer_regressor_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [31:0] modest_q(input int span);
    return 32'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(39))
      0:       return 32'($urandom);
      1:       return Q_MAX;
      2:       return Q_MIN;
      3:       return modest_q(Q_ONE / 64);
      4:       return '0;
      default: return modest_q(Q_TWO);
    endcase
  endfunction

  function automatic logic [9:0] pick_addr();
    case ($urandom_range(9))
      0, 1:    return 10'($urandom_range(1023));
      2:       return 10'($urandom_range(MODEL_WORDS - 1, OFS_IMEAN));
      default: return 10'($urandom_range(MODEL_WORDS - 1));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_reading();
    case ($urandom_range(19))
      0:       return 32'($urandom);
      1:       return Q_MAX;
      2:       return Q_MIN;
      default: return modest_q(8 * Q_ONE);
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load_word(input logic [9:0] addr, input logic signed [31:0] word);
    in_item_t it;
    it.func         = FUNC_LOAD;
    it.param_addr   = addr;
    it.param_word   = word;
    it.reading_254  = 32'($urandom);
    it.reading_550  = 32'($urandom);
    it.reading_temp = 32'($urandom);
    send_item(it);
  endtask

  task automatic run_sample(input logic signed [31:0] r254, input logic signed [31:0] r550,
                            input logic signed [31:0] rtemp);
    in_item_t it;
    it.func         = FUNC_INFER;
    it.param_addr   = 10'($urandom_range(1023));
    it.param_word   = 32'($urandom);
    it.reading_254  = r254;
    it.reading_550  = r550;
    it.reading_temp = rtemp;
    send_item(it);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  initial begin
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_item  <= '0;
    idle_pct = 34;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int a = 0; a < MODEL_WORDS; a++) begin
      param_image[a] = modest_q(Q_TWO);
      load_word(10'(a), param_image[a]);
    end

    run_sample('0, '0, '0);
    wait_drained();
    run_sample(Q_MAX, Q_MAX, Q_MAX);
    run_sample(Q_MIN, Q_MIN, Q_MIN);
    run_sample(Q_MAX, Q_MIN, '0);
    // standardiser saturates high, then low
    load_word(10'(OFS_IRECIP), Q_MAX);
    load_word(10'(OFS_IMEAN), Q_MIN);
    run_sample(Q_MAX, '0, '0);
    load_word(10'(OFS_IMEAN), Q_MAX);
    run_sample(Q_MIN, '0, '0);
    load_word(10'(OFS_IMEAN), param_image[OFS_IMEAN]);
    load_word(10'(OFS_IRECIP), param_image[OFS_IRECIP]);
    // output scaling at the extremes
    load_word(10'(OFS_OSCALE), Q_MAX);
    load_word(10'(OFS_OMEAN), Q_MAX);
    load_word(10'(OFS_OSCALE + 1), Q_MIN);
    load_word(10'(OFS_OMEAN + 1), Q_MIN);
    run_sample(modest_q(Q_ONE), modest_q(Q_ONE), modest_q(Q_ONE));
    for (int k = 0; k < 2 * RESULT_COUNT; k++)
      load_word(10'(OFS_OSCALE + k), param_image[OFS_OSCALE + k]);
    load_word(10'd1023, 32'hFFFF_FFFF);
    load_word(10'd1023, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) idle_pct = 45;
      else if (n == 2 * RANDOM_ITEMS / 3) idle_pct = 0;
      if ($urandom_range(99) < 3) wait_drained();
      if ($urandom_range(99) < 40) run_sample(pick_reading(), pick_reading(), pick_reading());
      else load_word(pick_addr(), pick_word());
    end

    start <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("mlp_three_layer_regressor_tb passed");
    end else begin
      $display("mlp_three_layer_regressor_tb failed");
    end
    $finish;
  end

endmodule

// ===== mlp_three_layer_regressor.f =====
rtl/mlp_pkg.sv
rtl/mlp_ctrl.sv
rtl/mlp_dp.sv
rtl/mlp_three_layer_regressor.sv
test/mlp_estimate_checker.sv
test/mlp_three_layer_regressor_tb.sv
